FILE: hdl/potb_pkg.sv
// Package for the periodic one-shot timer bank.
// Holds field widths, action and result codes, the result beat type and the
// saturating time adder. No dependencies.
package potb_pkg;

    localparam int TIME_W      = 48;
    localparam int DELAY_W     = 32;
    localparam int IDX_W       = 4;
    localparam int ACT_W       = 3;
    localparam int KIND_W      = 2;
    localparam int NUM_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int RAM_W       = TIME_W + 1 + DELAY_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_ARM    = 3'd2,
        ACT_CANCEL = 3'd3,
        ACT_QUERY  = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED   = 2'd0,
        KIND_IDLE    = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_REFUSED = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              result_kind;
        logic [IDX_W-1:0]   slot_out;
        logic               scheduled;
        logic [TIME_W-1:0]  remaining;
        logic               last;
    } t_result;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DELAY_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - DELAY_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

FILE: hdl/potb_if.sv
// Channel interfaces of the timer bank: command beats in, result beats out.
// Depends on potb_pkg.
interface potb_in_if;
    logic                               valid;
    logic                               ready;
    logic [potb_pkg::ACT_W-1:0]         action;
    logic [potb_pkg::IDX_W-1:0]         timer_index;
    logic [potb_pkg::TIME_W-1:0]        now;
    logic [potb_pkg::DELAY_W-1:0]       delay;
    logic                               periodic;
    logic [potb_pkg::DELAY_W-1:0]       repeat_interval;
    logic                               paused;

    modport source (output valid, action, timer_index, now, delay, periodic,
                    repeat_interval, paused, input ready);
    modport sink   (input valid, action, timer_index, now, delay, periodic,
                    repeat_interval, paused, output ready);
endinterface

interface potb_out_if;
    logic                               valid;
    logic                               ready;
    potb_pkg::t_kind                    result_kind;
    logic [potb_pkg::IDX_W-1:0]         slot_out;
    logic                               scheduled;
    logic [potb_pkg::TIME_W-1:0]        remaining;
    logic                               last;

    modport source (output valid, result_kind, slot_out, scheduled, remaining, last,
                    input ready);
    modport sink   (input valid, result_kind, slot_out, scheduled, remaining, last,
                    output ready);
endinterface

FILE: hdl/periodic_oneshot_timer_bank_unit.sv
// Top level of the periodic one-shot timer bank: command decode, slot scan, result register.
// Depends on potb_pkg, potb_if and potb_ram.
//
//  port     dir  beat contents
//  i_in     in   action, timer_index, now, delay, periodic, repeat_interval, paused
//  o_out    out  result_kind, slot_out, scheduled, remaining, last
//  i_cfg_*  in   pause_halts_dispatch, written by i_cfg_we
//
// Non-tick commands and halted ticks are accepted with a RAM read, then executed once the result register is free.
// A tick scans the slots in S_SCAN and ends in S_FIN: the scan visits one slot per cycle, unless it stalls,
// through the slot RAM read port, writing back the same cycle.
// Synchronous reset clears the exists and armed bits; RAM entries are used only when armed.
// A result register parts the sides; the scan holds while a second fire meets a full one.
module periodic_oneshot_timer_bank_unit #(
    parameter int NUM_TIMERS = potb_pkg::NUM_TIMERS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    potb_in_if.sink       i_in,
    potb_out_if.source    o_out
);
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW = potb_pkg::TIME_W;
    localparam int DW = potb_pkg::DELAY_W;

    typedef enum logic [1:0] {S_IDLE, S_CMD, S_SCAN, S_FIN} t_state;

    t_state                         r_state;
    logic                           r_halt;
    logic [NUM_TIMERS-1:0]          r_exists;
    logic [NUM_TIMERS-1:0]          r_armed;
    logic [AW-1:0]                  r_scan;
    logic [potb_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_pend_valid;
    logic [AW-1:0]                  r_pend_slot;
    logic                           r_out_valid;
    potb_pkg::t_result              r_out;

    logic [potb_pkg::ACT_W-1:0]     r_act;
    logic [potb_pkg::IDX_W-1:0]     r_idx;
    logic [TW-1:0]                  r_now;
    logic [DW-1:0]                  r_delay;
    logic                           r_per;
    logic [DW-1:0]                  r_rep;

    logic                           in_fire;
    logic                           out_free;
    logic                           idx_ok;
    logic [AW-1:0]                  slot_a;
    logic                           last_slot;
    logic                           due;
    logic                           stall;
    logic [TW-1:0]                  ft1;
    logic [TW-1:0]                  ft2;
    logic [TW-1:0]                  ft_new;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [potb_pkg::RAM_W-1:0]     ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [potb_pkg::RAM_W-1:0]     ram_rdata;
    logic [TW-1:0]                  rd_ft;
    logic                           rd_per;
    logic [DW-1:0]                  rd_iv;

    logic                           out_load;
    potb_pkg::t_result              n_out;

    potb_ram #(
        .WIDTH (potb_pkg::RAM_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ft  = ram_rdata[potb_pkg::RAM_W-1 -: TW];
    assign rd_per = ram_rdata[DW];
    assign rd_iv  = ram_rdata[DW-1:0];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign idx_ok    = (32'(r_idx) < 32'(NUM_TIMERS));
    assign slot_a    = AW'(r_idx);
    assign last_slot = (r_scan == AW'(NUM_TIMERS - 1));

    assign due   = r_armed[r_scan] && (rd_ft <= r_now)
                   && (r_cnt < potb_pkg::CNT_W'(potb_pkg::MAX_RESULTS));
    assign stall = due && r_pend_valid && !out_free;

    assign ft1    = potb_pkg::sat_add(rd_ft, rd_iv);
    assign ft2    = potb_pkg::sat_add(r_now, rd_iv);
    assign ft_new = ((rd_iv != '0) && (ft1 <= r_now)) ? ft2 : ft1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_a;
        ram_wdata = {potb_pkg::sat_add(r_now, r_delay), r_per, r_per ? r_rep : '0};
        ram_re    = 1'b0;
        ram_raddr = AW'(i_in.timer_index);
        out_load  = 1'b0;
        n_out     = '{result_kind: potb_pkg::KIND_DONE, slot_out: r_idx,
                      scheduled: 1'b0, remaining: '0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    ram_re = 1'b1;
                    if (i_in.action == potb_pkg::ACT_TICK) begin
                        ram_raddr = '0;
                    end
                end
            end
            S_CMD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    case (r_act)
                        potb_pkg::ACT_TICK: begin
                            n_out.result_kind = potb_pkg::KIND_IDLE;
                            n_out.slot_out    = '0;
                        end
                        potb_pkg::ACT_CREATE: begin
                            if (!(idx_ok && !r_exists[slot_a])) begin
                                n_out.result_kind = potb_pkg::KIND_REFUSED;
                            end
                        end
                        potb_pkg::ACT_ARM: begin
                            if (idx_ok && r_exists[slot_a]) begin
                                ram_we = 1'b1;
                            end else begin
                                n_out.result_kind = potb_pkg::KIND_REFUSED;
                            end
                        end
                        potb_pkg::ACT_CANCEL: begin
                            if (!(idx_ok && r_exists[slot_a])) begin
                                n_out.result_kind = potb_pkg::KIND_REFUSED;
                            end
                        end
                        potb_pkg::ACT_QUERY: begin
                            if (!(idx_ok && r_exists[slot_a])) begin
                                n_out.result_kind = potb_pkg::KIND_REFUSED;
                            end else if (r_armed[slot_a]) begin
                                n_out.scheduled = 1'b1;
                                n_out.remaining = (rd_ft > r_now) ? rd_ft - r_now : '0;
                            end
                        end
                        potb_pkg::ACT_CLEAR: begin
                            n_out.slot_out = '0;
                        end
                        default: begin
                            n_out.result_kind = potb_pkg::KIND_REFUSED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    ram_re    = !last_slot;
                    ram_raddr = r_scan + AW'(1);
                    if (due) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_scan;
                        ram_wdata = {rd_per ? ft_new : rd_ft, rd_per, rd_iv};
                        if (r_pend_valid) begin
                            out_load          = 1'b1;
                            n_out.result_kind = potb_pkg::KIND_FIRED;
                            n_out.slot_out    = potb_pkg::IDX_W'(r_pend_slot);
                            n_out.last        = 1'b0;
                        end
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_valid) begin
                        n_out.result_kind = potb_pkg::KIND_FIRED;
                        n_out.slot_out    = potb_pkg::IDX_W'(r_pend_slot);
                    end else begin
                        n_out.result_kind = potb_pkg::KIND_IDLE;
                        n_out.slot_out    = '0;
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_halt       <= 1'b1;
            r_exists     <= '0;
            r_armed      <= '0;
            r_scan       <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_halt <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_scan       <= '0;
                        r_cnt        <= '0;
                        r_pend_valid <= 1'b0;
                        if (i_in.action == potb_pkg::ACT_TICK
                            && !(i_in.paused && r_halt)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_CMD;
                        end
                    end
                end
                S_CMD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        case (r_act)
                            potb_pkg::ACT_CREATE: begin
                                if (idx_ok && !r_exists[slot_a]) begin
                                    r_exists[slot_a] <= 1'b1;
                                    r_armed[slot_a]  <= 1'b0;
                                end
                            end
                            potb_pkg::ACT_ARM: begin
                                if (idx_ok && r_exists[slot_a]) begin
                                    r_armed[slot_a] <= 1'b1;
                                end
                            end
                            potb_pkg::ACT_CANCEL: begin
                                if (idx_ok && r_exists[slot_a]) begin
                                    r_armed[slot_a] <= 1'b0;
                                end
                            end
                            potb_pkg::ACT_CLEAR: begin
                                r_exists <= '0;
                                r_armed  <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        if (due) begin
                            if (!rd_per) begin
                                r_armed[r_scan] <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_slot  <= r_scan;
                            r_cnt        <= r_cnt + potb_pkg::CNT_W'(1);
                        end
                        if (last_slot) begin
                            r_state <= S_FIN;
                        end else begin
                            r_scan <= r_scan + AW'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act   <= i_in.action;
            r_idx   <= i_in.timer_index;
            r_now   <= i_in.now;
            r_delay <= i_in.delay;
            r_per   <= i_in.periodic;
            r_rep   <= i_in.repeat_interval;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out.result_kind;
    assign o_out.slot_out    = r_out.slot_out;
    assign o_out.scheduled   = r_out.scheduled;
    assign o_out.remaining   = r_out.remaining;
    assign o_out.last        = r_out.last;

    a_armed_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed & ~r_exists) == '0)
        else $error("slot armed without existing");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= potb_pkg::CNT_W'(potb_pkg::MAX_RESULTS))
        else $error("fire count beyond limit");

    a_mid_is_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.result_kind == potb_pkg::KIND_FIRED))
        else $error("non-final beat that is not a fire");

    a_sched_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.scheduled) |-> (o_out.result_kind == potb_pkg::KIND_DONE))
        else $error("scheduled flag on a non-query result");

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && stall) |=> (r_state == S_SCAN && $stable(r_scan)))
        else $error("scan advanced during a stall");
endmodule

FILE: hdl/potb_ram.sv
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
module potb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: dv/tb_periodic_oneshot_timer_bank_unit.sv
`timescale 1ns / 1ps
// Testbench of periodic_oneshot_timer_bank_unit: a table of directed commands, then random
// phases under idling and back-pressure, every result beat checked against a pinned answer
// or a local model. Depends on potb_pkg, potb_if and the RTL of the timer bank.
module tb_periodic_oneshot_timer_bank_unit;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = potb_pkg::NUM_TIMERS + 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int HOLD_ITEMS    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_CAP    = 40;

    localparam logic [potb_pkg::ACT_W-1:0]  ACT_RSVD_A = 3'd6;
    localparam logic [potb_pkg::ACT_W-1:0]  ACT_RSVD_B = 3'd7;
    localparam logic [potb_pkg::TIME_W-1:0] TIME_TOP   = {potb_pkg::TIME_W{1'b1}};

    typedef struct {
        logic [potb_pkg::ACT_W-1:0]   action;
        logic [potb_pkg::IDX_W-1:0]   idx;
        logic [potb_pkg::TIME_W-1:0]  now;
        logic [potb_pkg::DELAY_W-1:0] delay;
        logic                         periodic;
        logic [potb_pkg::DELAY_W-1:0] interval;
        logic                         paused;
    } t_cmd;

    typedef struct {
        t_cmd              cmd;
        bit                typed;
        potb_pkg::t_result answer;
    } t_stim_row;

    typedef struct {
        bit                typed;
        potb_pkg::t_result answer;
    } t_pinned;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    potb_in_if  u_in_if ();
    potb_out_if u_out_if ();

    periodic_oneshot_timer_bank_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (u_in_if),
        .o_out       (u_out_if)
    );

    // timer bank state as the model keeps it
    logic [potb_pkg::NUM_TIMERS-1:0] slot_created;
    logic [potb_pkg::NUM_TIMERS-1:0] slot_running;
    logic [potb_pkg::NUM_TIMERS-1:0] slot_repeating;
    logic [potb_pkg::TIME_W-1:0]     due_time [potb_pkg::NUM_TIMERS];
    logic [potb_pkg::DELAY_W-1:0]    repeat_period [potb_pkg::NUM_TIMERS];
    logic                            halt_on_pause;

    potb_pkg::t_result expected_results[$];
    potb_pkg::t_result fresh_results[$];
    t_pinned           pinned_answers[$];
    t_stim_row         directed_rows[$];

    bit          in_beat;
    logic        hold_off;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatch_count;
    int          cycle_count;
    logic [potb_pkg::TIME_W-1:0] time_base;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        u_out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [potb_pkg::TIME_W-1:0] add_sat(
            input logic [potb_pkg::TIME_W-1:0] a,
            input logic [potb_pkg::TIME_W-1:0] b);
        logic [potb_pkg::TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[potb_pkg::TIME_W] ? TIME_TOP : sum[potb_pkg::TIME_W-1:0];
    endfunction

    task automatic emit_result(input potb_pkg::t_kind kind,
                               input logic [potb_pkg::IDX_W-1:0] slot,
                               input logic sched, input logic [potb_pkg::TIME_W-1:0] rem,
                               input logic last);
        potb_pkg::t_result r;
        r = '{kind, slot, sched, rem, last};
        fresh_results.insert(fresh_results.size(), r);
    endtask

    task automatic clear_bank();
        slot_created   = '0;
        slot_running   = '0;
        slot_repeating = '0;
        for (int s = 0; s < potb_pkg::NUM_TIMERS; s++) begin
            due_time[s]      = '0;
            repeat_period[s] = '0;
        end
    endtask

    task automatic predict_results(input t_cmd c);
        int                          fired;
        bit                          in_range;
        bit                          known;
        logic [potb_pkg::TIME_W-1:0] due;
        fresh_results.delete();
        in_range = c.idx < potb_pkg::NUM_TIMERS;
        known    = in_range && slot_created[c.idx];
        case (c.action)
            potb_pkg::ACT_TICK: begin
                if (c.paused && halt_on_pause) begin
                    emit_result(potb_pkg::KIND_IDLE, '0, 1'b0, '0, 1'b1);
                end else begin
                    fired = 0;
                    for (int s = 0; s < potb_pkg::NUM_TIMERS; s++) begin
                        if (fired < potb_pkg::MAX_RESULTS && slot_running[s]
                            && due_time[s] <= c.now) begin
                            if (!slot_repeating[s]) begin
                                slot_running[s] = 1'b0;
                            end else begin
                                due = add_sat(due_time[s],
                                              potb_pkg::TIME_W'(repeat_period[s]));
                                if (repeat_period[s] != '0 && due <= c.now) begin
                                    due = add_sat(c.now, potb_pkg::TIME_W'(repeat_period[s]));
                                end
                                due_time[s] = due;
                            end
                            emit_result(potb_pkg::KIND_FIRED, potb_pkg::IDX_W'(s), 1'b0, '0,
                                        1'b0);
                            fired++;
                        end
                    end
                    if (fired == 0) begin
                        emit_result(potb_pkg::KIND_IDLE, '0, 1'b0, '0, 1'b1);
                    end else begin
                        fresh_results[fresh_results.size() - 1].last = 1'b1;
                    end
                end
            end
            potb_pkg::ACT_CREATE: begin
                if (!in_range || slot_created[c.idx]) begin
                    emit_result(potb_pkg::KIND_REFUSED, c.idx, 1'b0, '0, 1'b1);
                end else begin
                    slot_created[c.idx]   = 1'b1;
                    slot_running[c.idx]   = 1'b0;
                    slot_repeating[c.idx] = 1'b0;
                    due_time[c.idx]       = '0;
                    repeat_period[c.idx]  = '0;
                    emit_result(potb_pkg::KIND_DONE, c.idx, 1'b0, '0, 1'b1);
                end
            end
            potb_pkg::ACT_ARM: begin
                if (!known) begin
                    emit_result(potb_pkg::KIND_REFUSED, c.idx, 1'b0, '0, 1'b1);
                end else begin
                    slot_running[c.idx]   = 1'b1;
                    due_time[c.idx]       = add_sat(c.now, potb_pkg::TIME_W'(c.delay));
                    slot_repeating[c.idx] = c.periodic;
                    repeat_period[c.idx]  = c.periodic ? c.interval : '0;
                    emit_result(potb_pkg::KIND_DONE, c.idx, 1'b0, '0, 1'b1);
                end
            end
            potb_pkg::ACT_CANCEL: begin
                if (!known) begin
                    emit_result(potb_pkg::KIND_REFUSED, c.idx, 1'b0, '0, 1'b1);
                end else begin
                    slot_running[c.idx] = 1'b0;
                    emit_result(potb_pkg::KIND_DONE, c.idx, 1'b0, '0, 1'b1);
                end
            end
            potb_pkg::ACT_QUERY: begin
                if (!known) begin
                    emit_result(potb_pkg::KIND_REFUSED, c.idx, 1'b0, '0, 1'b1);
                end else if (!slot_running[c.idx]) begin
                    emit_result(potb_pkg::KIND_DONE, c.idx, 1'b0, '0, 1'b1);
                end else begin
                    due = due_time[c.idx] > c.now ? due_time[c.idx] - c.now : '0;
                    emit_result(potb_pkg::KIND_DONE, c.idx, 1'b1, due, 1'b1);
                end
            end
            potb_pkg::ACT_CLEAR: begin
                clear_bank();
                emit_result(potb_pkg::KIND_DONE, '0, 1'b0, '0, 1'b1);
            end
            default: begin
                emit_result(potb_pkg::KIND_REFUSED, c.idx, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input potb_pkg::t_result got,
                                   input potb_pkg::t_result want);
        if (mismatch_count < REPORT_CAP) begin
            $display("mismatch at cycle %0d (%s): got kind %0d slot %0d sched %0b rem %0h last %0b,",
                     cycle_count, what, got.result_kind, got.slot_out, got.scheduled,
                     got.remaining, got.last,
                     " want kind %0d slot %0d sched %0b rem %0h last %0b",
                     want.result_kind, want.slot_out, want.scheduled, want.remaining, want.last);
        end
        mismatch_count++;
    endtask

    // sample at the falling edge: values here hold through the next rising edge
    always @(negedge i_clk) begin : watch_beats
        potb_pkg::t_result got;
        potb_pkg::t_result want;
        t_cmd              seen;
        t_pinned           pin;
        in_beat = i_rst_n && (u_in_if.valid === 1'b1) && (u_in_if.ready === 1'b1);
        if (i_rst_n && u_out_if.valid === 1'b1 && u_out_if.ready === 1'b1) begin
            got = '{u_out_if.result_kind, u_out_if.slot_out, u_out_if.scheduled,
                    u_out_if.remaining, u_out_if.last};
            if (expected_results.size() == 0) begin
                report_mismatch("no result expected", got, got);
            end else begin
                want = expected_results.pop_front();
                if (got.result_kind !== want.result_kind || got.slot_out !== want.slot_out ||
                    got.scheduled !== want.scheduled || got.remaining !== want.remaining ||
                    got.last !== want.last) begin
                    report_mismatch("field", got, want);
                end
            end
        end
        if (in_beat) begin
            seen.action   = u_in_if.action;
            seen.idx      = u_in_if.timer_index;
            seen.now      = u_in_if.now;
            seen.delay    = u_in_if.delay;
            seen.periodic = u_in_if.periodic;
            seen.interval = u_in_if.repeat_interval;
            seen.paused   = u_in_if.paused;
            predict_results(seen);
            pin = pinned_answers.pop_front();
            if (pin.typed) begin
                expected_results.insert(expected_results.size(), pin.answer);
            end else begin
                foreach (fresh_results[k]) begin
                    expected_results.insert(expected_results.size(), fresh_results[k]);
                end
            end
        end
    end

    function automatic t_stim_row row(input logic [potb_pkg::ACT_W-1:0] act,
                                      input logic [potb_pkg::IDX_W-1:0] idx,
                                      input logic [potb_pkg::TIME_W-1:0] now,
                                      input logic [potb_pkg::DELAY_W-1:0] dly,
                                      input logic per,
                                      input logic [potb_pkg::DELAY_W-1:0] ivl,
                                      input logic pau,
                                      input bit typed = 1'b0,
                                      input potb_pkg::t_kind kind = potb_pkg::KIND_FIRED,
                                      input logic [potb_pkg::IDX_W-1:0] slot = '0,
                                      input logic sched = 1'b0,
                                      input logic [potb_pkg::TIME_W-1:0] rem = '0);
        t_stim_row r;
        r.cmd    = '{act, idx, now, dly, per, ivl, pau};
        r.typed  = typed;
        r.answer = '{kind, slot, sched, rem, 1'b1};
        return r;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd        c;
        logic [63:0] wide;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 33)      c.action = potb_pkg::ACT_TICK;
        else if (pick < 45) c.action = potb_pkg::ACT_CREATE;
        else if (pick < 70) c.action = potb_pkg::ACT_ARM;
        else if (pick < 78) c.action = potb_pkg::ACT_CANCEL;
        else if (pick < 93) c.action = potb_pkg::ACT_QUERY;
        else if (pick < 96) c.action = potb_pkg::ACT_CLEAR;
        else                c.action = $urandom_range(1) ? ACT_RSVD_A : ACT_RSVD_B;
        c.idx = potb_pkg::IDX_W'($urandom_range(potb_pkg::NUM_TIMERS - 1));
        if (c.action == potb_pkg::ACT_TICK) time_base = time_base + $urandom_range(1500);
        wide = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 4)                             c.now = wide[potb_pkg::TIME_W-1:0];
        else if (pick < 7)                        c.now = TIME_TOP - $urandom_range(5000);
        else if (c.action == potb_pkg::ACT_TICK)  c.now = time_base;
        else                                      c.now = time_base + $urandom_range(300);
        pick = $urandom_range(99);
        c.delay = (pick < 6) ? $urandom : $urandom_range(6000);
        pick = $urandom_range(99);
        if (pick < 6)       c.interval = $urandom;
        else if (pick < 20) c.interval = '0;
        else                c.interval = $urandom_range(3000, 1);
        c.periodic = 1'($urandom_range(1));
        c.paused   = $urandom_range(99) < 20;
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c, input bit typed, input potb_pkg::t_result answer);
        t_pinned pin;
        pin.typed  = typed;
        pin.answer = answer;
        pinned_answers.insert(pinned_answers.size(), pin);
        while ($urandom_range(99) < send_idle_pct) begin
            u_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in_if.valid           <= 1'b1;
        u_in_if.action          <= c.action;
        u_in_if.timer_index     <= c.idx;
        u_in_if.now             <= c.now;
        u_in_if.delay           <= c.delay;
        u_in_if.periodic        <= c.periodic;
        u_in_if.repeat_interval <= c.interval;
        u_in_if.paused          <= c.paused;
        do @(posedge i_clk); while (!in_beat);
    endtask

    // drop valid, wait for every result, then let a scan in progress finish
    task automatic drain_results();
        u_in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pause_cfg(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        halt_on_pause = value;
    endtask

    task automatic run_phase(input logic cfg, input int idle_pct, input int stall_pct,
                             input int items);
        write_pause_cfg(cfg);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_cmd(random_cmd(), 1'b0, '0);
        drain_results();
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_wdata             = 1'b0;
        u_in_if.valid           = 1'b0;
        u_in_if.action          = '0;
        u_in_if.timer_index     = '0;
        u_in_if.now             = '0;
        u_in_if.delay           = '0;
        u_in_if.periodic        = 1'b0;
        u_in_if.repeat_interval = '0;
        u_in_if.paused          = 1'b0;
        u_out_if.ready          = 1'b0;
        hold_off                = 1'b0;
        send_idle_pct           = 0;
        recv_stall_pct          = 0;
        mismatch_count          = 0;
        cycle_count             = 0;
        time_base               = '0;
        halt_on_pause           = 1'b1;
        clear_bank();

        directed_rows = '{
            row(potb_pkg::ACT_QUERY, 4'd0, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd0),
            row(potb_pkg::ACT_ARM, 4'd3, 48'd10, 32'd5, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd3),
            row(potb_pkg::ACT_CANCEL, 4'd15, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd15),
            row(potb_pkg::ACT_TICK, 4'd0, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_IDLE, 4'd0),
            row(potb_pkg::ACT_CREATE, 4'd0, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd0),
            row(potb_pkg::ACT_CREATE, 4'd0, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd0),
            row(potb_pkg::ACT_CREATE, 4'd15, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd15),
            row(potb_pkg::ACT_QUERY, 4'd0, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd0),
            row(potb_pkg::ACT_ARM, 4'd0, 48'd100, 32'd50, 1'b0, 32'hFFFF_FFFF, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd0),
            row(potb_pkg::ACT_QUERY, 4'd0, 48'd120, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd0, 1'b1, 48'd30),
            row(potb_pkg::ACT_ARM, 4'd15, 48'd0, 32'd0, 1'b1, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd15),
            row(potb_pkg::ACT_TICK, 4'd0, TIME_TOP, 32'd0, 1'b0, 32'd0, 1'b1,
                1'b1, potb_pkg::KIND_IDLE, 4'd0),
            row(potb_pkg::ACT_TICK, 4'd0, 48'd100, 32'd0, 1'b0, 32'd0, 1'b0),
            row(potb_pkg::ACT_TICK, 4'd0, 48'd150, 32'd0, 1'b0, 32'd0, 1'b0),
            row(potb_pkg::ACT_QUERY, 4'd0, 48'd200, 32'd0, 1'b0, 32'd0, 1'b0),
            row(potb_pkg::ACT_CREATE, 4'd7, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd7),
            row(potb_pkg::ACT_ARM, 4'd7, TIME_TOP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd7),
            row(potb_pkg::ACT_QUERY, 4'd7, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd7, 1'b1, TIME_TOP),
            row(potb_pkg::ACT_TICK, 4'd0, TIME_TOP, 32'd0, 1'b0, 32'd0, 1'b0),
            row(potb_pkg::ACT_CANCEL, 4'd15, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd15),
            row(potb_pkg::ACT_ARM, 4'd15, 48'd1000, 32'd5, 1'b1, 32'd10, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd15),
            row(potb_pkg::ACT_TICK, 4'd0, 48'd1100, 32'd0, 1'b0, 32'd0, 1'b0),
            row(potb_pkg::ACT_QUERY, 4'd15, 48'd1100, 32'd0, 1'b0, 32'd0, 1'b0),
            row(ACT_RSVD_A, 4'd9, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd9),
            row(ACT_RSVD_B, 4'd2, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd2),
            row(potb_pkg::ACT_CLEAR, 4'd11, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_DONE, 4'd0),
            row(potb_pkg::ACT_QUERY, 4'd15, 48'd0, 32'd0, 1'b0, 32'd0, 1'b0,
                1'b1, potb_pkg::KIND_REFUSED, 4'd15)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].answer);
        end
        drain_results();

        run_phase(1'b0, 0, 0, PHASE_ITEMS);
        run_phase(1'b1, 81, 0, PHASE_ITEMS);
        run_phase(1'b0, 0, 81, PHASE_ITEMS);
        run_phase(1'b1, 26, 26, PHASE_ITEMS);

        // hold the result side while commands keep coming, so the input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (HOLD_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
        drain_results();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
